// File: rtl/core/dkst_pkg.sv
// Shared types, constants and date helper functions for the date keyed sorted table.
// Used by dkst_cell, date_keyed_sorted_table_top and the bench; depends on nothing else.
package dkst_pkg;

   localparam int DEF_TABLE_DEPTH = 32;
   localparam int KEY_W           = 23;
   localparam int POS_W           = 6;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_FIND   = 1'b1;

   localparam logic [1:0] ST_INSERTED  = 2'd0;
   localparam logic [1:0] ST_MATCH     = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   localparam logic [13:0] FIX_YEAR  = 14'd2019;
   localparam logic [3:0]  FIX_MONTH = 4'd12;
   localparam logic [4:0]  FIX_DAY   = 5'd31;

   // ceil(2^19 / 25): exact quotient for every 14-bit year.
   localparam logic [28:0] RECIP_25 = 29'd20972;

   typedef struct packed {
      logic               operation;
      logic [3:0]         entry_month;
      logic [4:0]         entry_day;
      logic [13:0]        entry_year;
      logic signed [31:0] entry_amount;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [3:0]         out_month;
      logic [4:0]         out_day;
      logic [13:0]        out_year;
      logic signed [31:0] out_amount;
      logic [POS_W-1:0]   position;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [3:0]         month;
      logic [4:0]         day;
      logic [13:0]        year;
      logic signed [31:0] amount;
   } rec_type;

   typedef struct packed {
      logic cmp_en;
      logic write_en;
   } cell_ctrl_type;

   function automatic logic [KEY_W-1:0] rec_key(input rec_type r);
      return {r.year, r.month, r.day};
   endfunction

   function automatic logic [4:0] rem25(input logic [13:0] y);
      logic [28:0] prod;
      logic [9:0]  q;
      logic [13:0] q25;
      prod = 29'(y) * RECIP_25;
      q    = prod[28:19];
      q25  = (14'(q) << 4) + (14'(q) << 3) + 14'(q);
      return 5'(y - q25);
   endfunction

   // Divisible by 4, and either not by 100 or also by 400.
   function automatic logic is_leap(input logic [13:0] y);
      logic not_by_25;
      not_by_25 = (rem25(y) != 5'd0);
      return (y[1:0] == 2'd0) && (not_by_25 || (y[3:0] == 4'd0));
   endfunction

   function automatic rec_type validate(input rec_type r);
      rec_type    v;
      logic [4:0] max_day;
      logic       checked;
      v       = r;
      max_day = 5'd0;
      checked = 1'b1;
      if (r.month inside {4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12}) begin
         max_day = 5'd31;
      end else if (r.month inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
         max_day = 5'd30;
      end else if (r.month == 4'd2) begin
         max_day = is_leap(r.year) ? 5'd29 : 5'd28;
      end else begin
         checked = 1'b0;
      end
      if (checked && ((r.day == 5'd0) || (r.day > max_day))) begin
         v.month = FIX_MONTH;
         v.day   = FIX_DAY;
         v.year  = FIX_YEAR;
      end
      return v;
   endfunction

endpackage

// File: rtl/core/dkst_cell.sv
// One slot of the sorted record chain: holds a record and its compare flags.
// On an insert it takes its left neighbor's record or the new one, or keeps its own. Uses dkst_pkg.
module dkst_cell (
   input  logic                      clock,
   input  dkst_pkg::cell_ctrl_type   ctrl,
   input  logic [dkst_pkg::KEY_W-1:0] cmp_key,
   input  logic                      in_use,
   input  logic                      at_end,
   input  logic                      a_left,
   input  dkst_pkg::rec_type         left_rec,
   input  dkst_pkg::rec_type         new_rec,
   output dkst_pkg::rec_type         rec,
   output logic                      gt,
   output logic                      lt,
   output logic                      a_self,
   output logic                      take_new
);
   import dkst_pkg::*;

   rec_type          rec_ff, rec_in;
   logic             gt_ff, gt_in;
   logic             lt_ff, lt_in;
   logic [KEY_W-1:0] key;

   always_comb begin
      key    = rec_key(rec_ff);
      gt_in  = in_use && (key > cmp_key);
      lt_in  = in_use && (key < cmp_key);
      // A cell at or after the insert point moves up one place; the free slot
      // just past the last record counts as after it.
      a_self   = gt_ff | at_end;
      take_new = a_self & ~a_left;
      rec_in   = rec_ff;
      if (ctrl.write_en) begin
         if (a_left) begin
            rec_in = left_rec;
         end else if (take_new) begin
            rec_in = new_rec;
         end
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      if (ctrl.cmp_en) begin
         gt_ff <= gt_in;
         lt_ff <= lt_in;
      end
   end

   assign rec = rec_ff;
   assign gt  = gt_ff;
   assign lt  = lt_ff;

endmodule

// File: rtl/core/date_keyed_sorted_table_top.sv
// Date keyed sorted table: a chain of record cells with a search and emit sequencer.
// Insert: the request passes through the check, compare and insert states and the result is registered
// in the insert state; the next transfer is taken once the sequencer is back in idle. Find: after the
// compare state a search runs at most log2(depth)+1 halving steps, then matches are emitted one result per
// cycle while the result is not stalled; the next transfer is taken with the last result. Reset clears the
// record count, sequencer and result valid flag; cell contents stay.
module date_keyed_sorted_table_top #(
   parameter int TABLE_DEPTH = dkst_pkg::DEF_TABLE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dkst_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dkst_pkg::rsp_type rsp_data
);
   import dkst_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_CMP, S_INSERT, S_SEARCH, S_UP, S_DOWN
   } state_type;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   rec_type          work_ff, work_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] low_ff, low_in;
   logic [CNT_W-1:0] hi1_ff, hi1_in;
   logic [IDX_W-1:0] hit_ff, hit_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   cell_ctrl_type    cell_ctrl;
   rec_type          cell_rec [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] gt_vec, lt_vec, eq_vec, a_vec, take_new_vec;
   logic [IDX_W-1:0] ins_pos;

   rec_type          raw_rec, cur_rec;
   logic             can_emit, more_up, more_down, more_below;
   logic [CNT_W:0]   mid_sum;
   logic [IDX_W-1:0] mid_idx;
   logic [CNT_W-1:0] idx_next;

   genvar i;
   generate
      for (i = 0; i < TABLE_DEPTH; i++) begin : g_cell
         logic    a_left;
         rec_type left_rec;
         if (i == 0) begin : g_first
            assign a_left   = 1'b0;
            assign left_rec = cell_rec[0];
         end else begin : g_rest
            assign a_left   = a_vec[i-1];
            assign left_rec = cell_rec[i-1];
         end
         dkst_cell u_cell (
            .clock    (clock),
            .ctrl     (cell_ctrl),
            .cmp_key  (rec_key(work_ff)),
            .in_use   (CNT_W'(i) < count_ff),
            .at_end   (CNT_W'(i) == count_ff),
            .a_left   (a_left),
            .left_rec (left_rec),
            .new_rec  (work_ff),
            .rec      (cell_rec[i]),
            .gt       (gt_vec[i]),
            .lt       (lt_vec[i]),
            .a_self   (a_vec[i]),
            .take_new (take_new_vec[i])
         );
      end
   endgenerate

   assign eq_vec = ~gt_vec & ~lt_vec;

   always_comb begin
      ins_pos = '0;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         if (take_new_vec[k]) begin
            ins_pos = ins_pos | IDX_W'(k);
         end
      end
   end

   always_comb begin
      raw_rec.month  = req_ff.entry_month;
      raw_rec.day    = req_ff.entry_day;
      raw_rec.year   = req_ff.entry_year;
      raw_rec.amount = req_ff.entry_amount;
      cur_rec    = cell_rec[idx_ff];
      can_emit   = !rsp_valid_ff || !rsp_stall;
      mid_sum    = (CNT_W+1)'(low_ff) + (CNT_W+1)'(hi1_ff) - (CNT_W+1)'(1);
      mid_idx    = IDX_W'(mid_sum >> 1);
      idx_next   = CNT_W'(idx_ff) + CNT_W'(1);
      more_up    = (idx_next < count_ff) && eq_vec[idx_ff + IDX_W'(1)];
      more_down  = (hit_ff != '0) && eq_vec[hit_ff - IDX_W'(1)];
      more_below = (idx_ff != '0) && eq_vec[idx_ff - IDX_W'(1)];

      state_in     = state_ff;
      req_in       = req_ff;
      work_in      = work_ff;
      count_in     = count_ff;
      low_in       = low_ff;
      hi1_in       = hi1_ff;
      hit_in       = hit_ff;
      idx_in       = idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cell_ctrl    = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            work_in  = (req_ff.operation == OP_INSERT) ? validate(raw_rec) : raw_rec;
            state_in = S_CMP;
         end
         S_CMP: begin
            cell_ctrl.cmp_en = 1'b1;
            low_in   = '0;
            hi1_in   = count_ff;
            state_in = (req_ff.operation == OP_INSERT) ? S_INSERT : S_SEARCH;
         end
         S_INSERT: begin
            if (can_emit) begin
               rsp_valid_in      = 1'b1;
               rsp_in.out_month  = work_ff.month;
               rsp_in.out_day    = work_ff.day;
               rsp_in.out_year   = work_ff.year;
               rsp_in.out_amount = work_ff.amount;
               rsp_in.last       = 1'b1;
               if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                  cell_ctrl.write_en = 1'b1;
                  count_in        = count_ff + CNT_W'(1);
                  rsp_in.status   = ST_INSERTED;
                  rsp_in.position = POS_W'(ins_pos);
               end else begin
                  rsp_in.status   = ST_FULL;
                  rsp_in.position = '0;
               end
               state_in = S_IDLE;
            end
         end
         S_SEARCH: begin
            if (low_ff < hi1_ff) begin
               if (lt_vec[mid_idx]) begin
                  low_in = CNT_W'(mid_idx) + CNT_W'(1);
               end else if (gt_vec[mid_idx]) begin
                  hi1_in = CNT_W'(mid_idx);
               end else begin
                  hit_in   = mid_idx;
                  idx_in   = mid_idx;
                  state_in = S_UP;
               end
            end else if (can_emit) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               rsp_in.status = ST_NOT_FOUND;
               rsp_in.last   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_UP: begin
            if (can_emit) begin
               rsp_valid_in      = 1'b1;
               rsp_in.status     = ST_MATCH;
               rsp_in.out_month  = cur_rec.month;
               rsp_in.out_day    = cur_rec.day;
               rsp_in.out_year   = cur_rec.year;
               rsp_in.out_amount = cur_rec.amount;
               rsp_in.position   = POS_W'(idx_ff);
               rsp_in.last       = !more_up && !more_down;
               if (more_up) begin
                  idx_in = idx_ff + IDX_W'(1);
               end else if (more_down) begin
                  idx_in   = hit_ff - IDX_W'(1);
                  state_in = S_DOWN;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_DOWN: begin
            if (can_emit) begin
               rsp_valid_in      = 1'b1;
               rsp_in.status     = ST_MATCH;
               rsp_in.out_month  = cur_rec.month;
               rsp_in.out_day    = cur_rec.day;
               rsp_in.out_year   = cur_rec.year;
               rsp_in.out_amount = cur_rec.amount;
               rsp_in.position   = POS_W'(idx_ff);
               rsp_in.last       = !more_below;
               if (more_below) begin
                  idx_in = idx_ff - IDX_W'(1);
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff  <= req_in;
      work_ff <= work_in;
      low_ff  <= low_in;
      hi1_ff  <= hi1_in;
      hit_ff  <= hit_in;
      idx_ff  <= idx_in;
      rsp_ff  <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("record count above table depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      cell_ctrl.write_en |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("record count did not advance after an insert");

   a_one_slot: assert property (@(posedge clock) disable iff (reset)
      cell_ctrl.write_en |-> $onehot(take_new_vec))
      else $error("insert did not pick exactly one cell");

   a_emit_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UP || state_ff == S_DOWN) |-> CNT_W'(idx_ff) < count_ff)
      else $error("match walk left the filled part of the table");

   a_search_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SEARCH |-> hi1_ff <= count_ff)
      else $error("search window beyond the record count");

endmodule

// File: bench/date_keyed_sorted_table_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for date_keyed_sorted_table_top: directed and random inserts and finds,
// checked against a scoreboard that keeps its own sorted copy of the table.
// Depends on dkst_pkg and the date_keyed_sorted_table_top RTL.
module date_keyed_sorted_table_top_test;
   import dkst_pkg::*;

   localparam int DEPTH        = DEF_TABLE_DEPTH;
   localparam int RANDOM_ITEMS = 420;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 64;

   class table_scoreboard;
      rec_type rows[DEPTH];
      int      used;
      rsp_type due[$];
      int      accepted, inserts, refused, finds, misses, checked, errors;

      function int pending();
         return due.size();
      endfunction

      static function logic [KEY_W-1:0] sort_key(rec_type r);
         return {r.year, r.month, r.day};
      endfunction

      // Days outside the month become the fallback date; unknown months pass untouched.
      static function rec_type fix_date(rec_type r);
         rec_type     v;
         int unsigned top_day;
         logic        leap;
         logic        known;
         v       = r;
         known   = 1'b1;
         top_day = 0;
         leap    = (r.year % 4 == 0) && ((r.year % 100 != 0) || (r.year % 400 == 0));
         case (r.month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: top_day = 31;
            4'd4, 4'd6, 4'd9, 4'd11: top_day = 30;
            4'd2: top_day = leap ? 29 : 28;
            default: known = 1'b0;
         endcase
         if (known && (r.day == 0 || r.day > top_day)) begin
            v.month = FIX_MONTH;
            v.day   = FIX_DAY;
            v.year  = FIX_YEAR;
         end
         return v;
      endfunction

      function rsp_type match_at(int idx);
         rsp_type e;
         e            = '0;
         e.status     = ST_MATCH;
         e.out_month  = rows[idx].month;
         e.out_day    = rows[idx].day;
         e.out_year   = rows[idx].year;
         e.out_amount = rows[idx].amount;
         e.position   = idx[POS_W-1:0];
         return e;
      endfunction

      function void predict_insert(rec_type raw);
         rec_type r;
         rsp_type e;
         int      slot;
         int      i;
         r = fix_date(raw);
         inserts++;
         e            = '0;
         e.out_month  = r.month;
         e.out_day    = r.day;
         e.out_year   = r.year;
         e.out_amount = r.amount;
         e.last       = 1'b1;
         if (used >= DEPTH) begin
            refused++;
            e.status = ST_FULL;
         end else begin
            // Stable placement: after every stored date that is not later.
            slot = used;
            while (slot > 0 && sort_key(rows[slot - 1]) > sort_key(r)) slot--;
            for (i = used; i > slot; i--) rows[i] = rows[i - 1];
            rows[slot] = r;
            used++;
            e.status   = ST_INSERTED;
            e.position = slot[POS_W-1:0];
         end
         due = {due, e};
      endfunction

      function void predict_find(logic [KEY_W-1:0] want);
         rsp_type e;
         rsp_type run[$];
         int      lo, hi, mid, hit, i;
         finds++;
         lo  = 0;
         hi  = used - 1;
         hit = -1;
         while (hi >= lo) begin
            mid = (lo + hi) / 2;
            if (want > sort_key(rows[mid])) begin
               lo = mid + 1;
            end else if (sort_key(rows[mid]) > want) begin
               hi = mid - 1;
            end else begin
               hit = mid;
               break;
            end
         end
         if (hit < 0) begin
            misses++;
            e        = '0;
            e.status = ST_NOT_FOUND;
            e.last   = 1'b1;
            due = {due, e};
         end else begin
            // The hit first, then equal dates above it, then equal dates below it.
            run = {run, match_at(hit)};
            for (i = hit + 1; i < used && sort_key(rows[i]) == want; i++)
               run = {run, match_at(i)};
            for (i = hit - 1; i >= 0 && sort_key(rows[i]) == want; i--)
               run = {run, match_at(i)};
            e      = run[run.size() - 1];
            e.last = 1'b1;
            run[run.size() - 1] = e;
            due = {due, run};
         end
      endfunction

      function void note_request(req_type q);
         rec_type r;
         accepted++;
         r.month  = q.entry_month;
         r.day    = q.entry_day;
         r.year   = q.entry_year;
         r.amount = q.entry_amount;
         if (q.operation == OP_INSERT) begin
            predict_insert(r);
         end else begin
            predict_find(sort_key(r));
         end
      endfunction

      function void same(string field, logic signed [63:0] want, logic signed [63:0] got);
         if (want !== got) begin
            errors++;
            $error("%s: expected %0d, got %0d", field, want, got);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (due.size() == 0) begin
            errors++;
            $error("result with nothing outstanding: status %0d position %0d",
                   got.status, got.position);
         end else begin
            want = due.pop_front();
            checked++;
            same("status", want.status, got.status);
            same("out_month", want.out_month, got.out_month);
            same("out_day", want.out_day, got.out_day);
            same("out_year", want.out_year, got.out_year);
            same("out_amount", want.out_amount, got.out_amount);
            same("position", want.position, got.position);
            same("last", want.last, got.last);
         end
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      cycles    = 0;

   table_scoreboard book = new();
   rec_type         date_pool[6];

   date_keyed_sorted_table_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $error("timed out after %0d cycles with %0d results outstanding",
                cycles, book.pending());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic in_quiet_stretch();
      return book.accepted >= 150 && book.accepted < 270;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            book.check_result(rsp_data);
         end
         rsp_stall <= !in_quiet_stretch() && ($urandom_range(99) < 7);
      end
   end

   function automatic rec_type on_day(int y, int m, int d, logic [31:0] amt);
      rec_type r;
      r.year   = y[13:0];
      r.month  = m[3:0];
      r.day    = d[4:0];
      r.amount = amt;
      return r;
   endfunction

   function automatic req_type make_item(logic op, rec_type r);
      req_type q;
      q.operation    = op;
      q.entry_month  = r.month;
      q.entry_day    = r.day;
      q.entry_year   = r.year;
      q.entry_amount = r.amount;
      return q;
   endfunction

   // Mostly dates from a small pool, so that runs of equal dates build up in the table.
   function automatic req_type random_item();
      rec_type r;
      rec_type p;
      int      roll;
      roll     = $urandom_range(99);
      r        = on_day($urandom_range(9999), $urandom_range(15), $urandom_range(31), $urandom);
      p        = date_pool[$urandom_range(5)];
      p.amount = r.amount;
      if ($urandom_range(99) < 25) begin
         if (roll < 80) r = p;
         return make_item(OP_INSERT, r);
      end
      if (roll < 55) begin
         r = table_scoreboard::fix_date(p);
      end else if (roll < 70) begin
         r = p;
      end else if (roll < 85 && book.used > 0) begin
         r = book.rows[$urandom_range(book.used - 1)];
      end
      return make_item(OP_FIND, r);
   endfunction

   task automatic send_item(input req_type item);
      while (!in_quiet_stretch() && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.note_request(item);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   initial begin
      req_type opening[$];
      int      k;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      opening = {opening, make_item(OP_FIND, on_day(2024, 3, 15, 0))};
      opening = {opening, make_item(OP_INSERT, on_day(2024, 2, 29, 100))};
      opening = {opening, make_item(OP_INSERT, on_day(2023, 2, 29, 32'hFFFF_FFFF))};
      opening = {opening, make_item(OP_INSERT, on_day(1900, 2, 29, 32'h7FFF_FFFF))};
      opening = {opening, make_item(OP_INSERT, on_day(2000, 2, 29, 32'h8000_0000))};
      opening = {opening, make_item(OP_INSERT, on_day(2024, 4, 31, 7))};
      opening = {opening, make_item(OP_INSERT, on_day(2024, 1, 0, 8))};
      opening = {opening, make_item(OP_INSERT, on_day(2024, 12, 31, 0))};
      opening = {opening, make_item(OP_INSERT, on_day(0, 0, 0, 1))};
      opening = {opening, make_item(OP_INSERT, on_day(9999, 15, 31, 32'hFFFF_FFFE))};
      opening = {opening, make_item(OP_INSERT, on_day(8191, 13, 17, 32'h5555_AAAA))};
      opening = {opening, make_item(OP_INSERT, on_day(2024, 11, 30, 32'hAAAA_5555))};
      opening = {opening, make_item(OP_INSERT, on_day(2024, 6, 31, 9))};
      opening = {opening, make_item(OP_INSERT, on_day(2021, 2, 28, 10))};
      opening = {opening, make_item(OP_INSERT, on_day(2021, 2, 28, 11))};
      // Several invalid dates above collapsed onto the fallback date.
      opening = {opening, make_item(OP_FIND, on_day(2019, 12, 31, 0))};
      opening = {opening, make_item(OP_FIND, on_day(2021, 2, 28, 0))};
      opening = {opening, make_item(OP_FIND, on_day(2000, 2, 29, 0))};
      opening = {opening, make_item(OP_FIND, on_day(0, 0, 0, 0))};
      opening = {opening, make_item(OP_FIND, on_day(9999, 15, 31, 0))};
      // Queries are not validated, so these find nothing.
      opening = {opening, make_item(OP_FIND, on_day(2024, 2, 30, 0))};
      opening = {opening, make_item(OP_FIND, on_day(2024, 4, 31, 0))};
      opening = {opening, make_item(OP_FIND, on_day(9999, 15, 30, 32'hFFFF_FFFF))};
      foreach (opening[i]) send_item(opening[i]);
      hold_until_drained();

      date_pool[0] = on_day(2021, 2, 28, 0);
      date_pool[1] = on_day(2024, 4, 31, 0);
      date_pool[2] = on_day(9999, 14, 3, 0);
      date_pool[3] = on_day($urandom_range(9999), $urandom_range(1, 12), $urandom_range(1, 28), 0);
      date_pool[4] = on_day($urandom_range(9999), $urandom_range(1, 12), $urandom_range(1, 28), 0);
      date_pool[5] = on_day($urandom_range(9999), 2, $urandom_range(28, 31), 0);

      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == RANDOM_ITEMS / 2) hold_until_drained();
         send_item(random_item());
      end
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d inserts (%0d refused on a full table) and %0d finds (%0d misses).",
               book.inserts, book.refused, book.finds, book.misses);
      $display("%0d results checked over %0d cycles, %0d mismatches.",
               book.checked, cycles, book.errors);
      if (book.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
